[src/srh_pkg.sv]
// shared types, codes and constants of the sequence reorder heap
`default_nettype none
package srh_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned SEQ_W        = 16;
  localparam int unsigned HANDLE_W     = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam logic ST_RELEASE = 1'b0;
  localparam logic ST_DROP    = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [SEQ_W-1:0]    seq_in;
    logic [HANDLE_W-1:0] ref_in;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq_out;
    logic [HANDLE_W-1:0] ref_out;
    logic                status;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DROP,
    S_LOAD,
    S_CUR,
    S_FETCH,
    S_CMP,
    S_ROOT,
    S_CHECK,
    S_PUSH,
    S_LAST,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    ADDR_I,
    ADDR_LAST,
    ADDR_ROOT,
    ADDR_KIDS
  } addr_sel_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_DROP,
    OUT_MID,
    OUT_LAST
  } out_sel_e;

  typedef enum logic [1:0] {
    START_NONE,
    START_INIT,
    START_DEC
  } start_op_e;

  typedef struct packed {
    logic      ins_wr;
    logic      cap_item;
    start_op_e start_op;
    logic      i_zero;
    addr_sel_e addr_sel;
    logic      ld_cur;
    logic      cmp_wr;
    logic      ld_root;
    logic      pop;
    out_sel_e  out_sel;
  } cmd_t;

  typedef struct packed {
    logic in_flush;
    logic full;
    logic few;
    logic start_zero;
    logic best_is_i;
    logic match;
    logic slot_free;
    logic pend_v;
  } stat_t;

endpackage
`default_nettype wire

[src/sequence_reorder_heap.sv]
// top level of the sequence reorder heap: controller plus datapath
//
//  channel | valid        | stall        | payload                       | dir
//  --------+--------------+--------------+-------------------------------+----
//  input   | in_valid_i   | in_stall_o   | in_item_i  (opcode, seq, ref) | in
//  output  | out_valid_o  | out_stall_i  | out_item_o (seq, ref, st, ls) | out
//
// insert: the beat is written straight to the next free slot; a full store drops it
// flush: bottom-up rebuild of the whole store, then pops while root == expected;
//   each sift is a load step, then per level a child read and a compare and write,
//   kept apart by the registered reads of the entry memory; a pop goes through
//   root read, check and push (which waits for a free output slot) ahead of its sift
// release results are held back by one pop so the final one can carry last
// input stalls from a flush or drop until its results are all in the output
// register; no clearing pass, the store is tracked by its fill count
`default_nettype none
module sequence_reorder_heap #(
  parameter int unsigned CAPACITY = srh_pkg::CAPACITY_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire srh_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output srh_pkg::out_item_t      out_item_o
);
  import srh_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  srh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // entry memory, sift compare, pending release and output register
  srh_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

[src/srh_dp.sv]
// datapath of the sequence reorder heap: entry memory, sift compare, output register
`default_nettype none
module srh_dp #(
  parameter int unsigned CAPACITY = srh_pkg::CAPACITY_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire srh_pkg::in_item_t in_item_i,
  input  wire logic              out_stall_i,
  input  wire srh_pkg::cmd_t     cmd_i,
  output srh_pkg::stat_t         stat_o,
  output logic                   out_valid_o,
  output srh_pkg::out_item_t     out_item_o
);
  import srh_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned KID_W = IDX_W + 2;

  entry_t mem [CAPACITY];

  logic [CNT_W-1:0] count_q;
  logic [SEQ_W-1:0] next_q;
  logic [IDX_W-1:0] start_q, i_q;
  entry_t           item_q, cur_q, rd_a_q, rd_b_q, root_q, pend_q;
  logic             pend_v_q;
  out_item_t        out_q;
  logic             out_v_q;

  logic [KID_W-1:0] lw, rw;
  logic             l_ok, r_ok, l_lt, r_lt;
  logic [SEQ_W-1:0] bkey;
  entry_t           cmp_val;
  logic [IDX_W-1:0] addr_a, addr_b, wr_addr, start_init, kid_idx;
  logic [CNT_W-1:0] cnt_m2;
  logic             wr_en;
  entry_t           wr_data;
  logic             slot_free;

  // children of the node being sifted
  assign lw = {1'b0, i_q, 1'b1};
  assign rw = lw + KID_W'(1);
  assign l_ok = lw < KID_W'(count_q);
  assign r_ok = rw < KID_W'(count_q);

  // strict less-than keeps the parent on ties, left child before right
  always_comb begin
    l_lt    = l_ok && (rd_a_q.key < cur_q.key);
    bkey    = l_lt ? rd_a_q.key : cur_q.key;
    r_lt    = r_ok && (rd_b_q.key < bkey);
    cmp_val = r_lt ? rd_b_q : (l_lt ? rd_a_q : cur_q);
    kid_idx = r_lt ? rw[IDX_W-1:0] : lw[IDX_W-1:0];
  end

  assign cnt_m2     = count_q - CNT_W'(2);
  assign start_init = IDX_W'(cnt_m2 >> 1);

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_I:    addr_a = i_q;
      ADDR_LAST: addr_a = count_q[IDX_W-1:0];
      ADDR_ROOT: addr_a = '0;
      ADDR_KIDS: addr_a = lw[IDX_W-1:0];
      default:   addr_a = '0;
    endcase
    addr_b = rw[IDX_W-1:0];
  end

  always_comb begin
    wr_en   = cmd_i.ins_wr || cmd_i.cmp_wr;
    wr_addr = cmd_i.ins_wr ? count_q[IDX_W-1:0] : i_q;
    wr_data = cmd_i.ins_wr ? entry_t'{key: in_item_i.seq_in, handle: in_item_i.ref_in}
                           : cmp_val;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      item_q <= entry_t'{key: in_item_i.seq_in, handle: in_item_i.ref_in};
    end
    if (cmd_i.ld_cur) begin
      cur_q <= rd_a_q;
    end
    if (cmd_i.ld_root) begin
      root_q <= rd_a_q;
    end
    if (cmd_i.pop) begin
      pend_q <= root_q;
    end
    case (cmd_i.start_op)
      START_INIT: start_q <= start_init;
      START_DEC:  start_q <= start_q - IDX_W'(1);
      default:    start_q <= start_q;
    endcase
    if (cmd_i.i_zero) begin
      i_q <= '0;
    end else if (cmd_i.start_op == START_INIT) begin
      i_q <= start_init;
    end else if (cmd_i.start_op == START_DEC) begin
      i_q <= start_q - IDX_W'(1);
    end else if (cmd_i.cmp_wr && (l_lt || r_lt)) begin
      i_q <= kid_idx;
    end
    case (cmd_i.out_sel)
      OUT_DROP: out_q <= '{seq_out: item_q.key, ref_out: item_q.handle,
                           status: ST_DROP, last: 1'b1};
      OUT_MID:  out_q <= '{seq_out: pend_q.key, ref_out: pend_q.handle,
                           status: ST_RELEASE, last: 1'b0};
      OUT_LAST: out_q <= '{seq_out: pend_q.key, ref_out: pend_q.handle,
                           status: ST_RELEASE, last: 1'b1};
      default:  out_q <= out_q;
    endcase
  end

  assign slot_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      next_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.ins_wr) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.pop) begin
        next_q   <= next_q + SEQ_W'(1);
        pend_v_q <= 1'b1;
      end else if (cmd_i.out_sel == OUT_LAST) begin
        pend_v_q <= 1'b0;
      end
      if (cmd_i.out_sel != OUT_NONE) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.in_flush   = in_item_i.opcode == OP_FLUSH;
    stat_o.full       = count_q == CNT_W'(CAPACITY);
    stat_o.few        = count_q < CNT_W'(2);
    stat_o.start_zero = start_q == '0;
    stat_o.best_is_i  = !l_lt && !r_lt;
    stat_o.match      = (count_q != '0) && (rd_a_q.key == next_q);
    stat_o.slot_free  = slot_free;
    stat_o.pend_v     = pend_v_q;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_sel != OUT_NONE) |-> slot_free)
    else $error("output loaded over a waiting beat");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_wr |-> (count_q < CNT_W'(CAPACITY)))
    else $error("insert into full store");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (count_q != '0))
    else $error("pop from empty store");

  a_pop_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> (next_q == $past(next_q) + SEQ_W'(1)))
    else $error("expected number did not advance on pop");

  a_mid_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.out_sel == OUT_MID) || (cmd_i.out_sel == OUT_LAST)) |-> pend_v_q)
    else $error("release emitted without a pending entry");

endmodule
`default_nettype wire

[src/srh_ctrl.sv]
// controller of the sequence reorder heap: insert, heap rebuild, sift and pop sequencing
`default_nettype none
module srh_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire srh_pkg::stat_t stat_i,
  output srh_pkg::cmd_t       cmd_o
);
  import srh_pkg::*;

  state_e state_q, state_d;
  logic   building_q, building_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      building_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      building_q <= building_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    building_d = building_q;
    cmd_o      = '{ins_wr: 1'b0, cap_item: 1'b0, start_op: START_NONE, i_zero: 1'b0,
                   addr_sel: ADDR_I, ld_cur: 1'b0, cmp_wr: 1'b0, ld_root: 1'b0,
                   pop: 1'b0, out_sel: OUT_NONE};
    in_stall_o = state_q != S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          if (stat_i.in_flush) begin
            if (stat_i.few) begin
              state_d = S_ROOT;
            end else begin
              cmd_o.start_op = START_INIT;
              building_d     = 1'b1;
              state_d        = S_LOAD;
            end
          end else if (stat_i.full) begin
            state_d = S_DROP;
          end else begin
            cmd_o.ins_wr = 1'b1;
          end
        end
      end
      S_DROP: begin
        if (stat_i.slot_free) begin
          cmd_o.out_sel = OUT_DROP;
          state_d       = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd_o.addr_sel = ADDR_I;
        state_d        = S_CUR;
      end
      S_CUR: begin
        cmd_o.ld_cur   = 1'b1;
        cmd_o.addr_sel = ADDR_KIDS;
        state_d        = S_CMP;
      end
      S_FETCH: begin
        cmd_o.addr_sel = ADDR_KIDS;
        state_d        = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp_wr = 1'b1;
        if (!stat_i.best_is_i) begin
          state_d = S_FETCH;
        end else if (building_q && !stat_i.start_zero) begin
          cmd_o.start_op = START_DEC;
          state_d        = S_LOAD;
        end else begin
          building_d = 1'b0;
          state_d    = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.addr_sel = ADDR_ROOT;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.ld_root = 1'b1;
        state_d       = stat_i.match ? S_PUSH : S_FIN;
      end
      S_PUSH: begin
        if (!stat_i.pend_v || stat_i.slot_free) begin
          if (stat_i.pend_v) begin
            cmd_o.out_sel = OUT_MID;
          end
          cmd_o.pop    = 1'b1;
          cmd_o.i_zero = 1'b1;
          state_d      = S_LAST;
        end
      end
      S_LAST: begin
        cmd_o.addr_sel = ADDR_LAST;
        state_d        = S_CUR;
      end
      S_FIN: begin
        if (!stat_i.pend_v) begin
          state_d = S_IDLE;
        end else if (stat_i.slot_free) begin
          cmd_o.out_sel = OUT_LAST;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d    = S_IDLE;
        building_d = 1'b0;
      end
    endcase
  end

  a_build_in_sift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    building_q |-> ((state_q == S_LOAD) || (state_q == S_CUR) ||
                    (state_q == S_FETCH) || (state_q == S_CMP)))
    else $error("rebuild flag set outside the sift loop");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.ins_wr || cmd_o.cap_item) |-> (state_q == S_IDLE) && in_valid_i)
    else $error("input taken outside idle");

  a_pop_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> (($past(state_q) == S_CHECK) || ($past(state_q) == S_PUSH)))
    else $error("pop without root check");

endmodule
`default_nettype wire
